// ----- hw/rtl/eot_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package eot_pkg;

	// Pool geometry
	localparam int SLOTS_PER_CLASS_DEF = 4;
	localparam int NUM_CLASSES         = 3;

	// Field widths
	localparam int CMD_W      = 2;
	localparam int CLS_W      = 2;
	localparam int TAG_W      = 32;
	localparam int XD_W       = 8;
	localparam int KIND_W     = 2;
	localparam int POOL_W     = 3;
	localparam int DELAY_W    = 8;
	localparam int CD_W       = 9;
	localparam int REG_IDX_W  = 3;
	localparam int REG_DATA_W = 8;

	// Depth of the queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// Commands
	localparam logic [CMD_W-1:0] CMD_QUERY = 2'd0;
	localparam logic [CMD_W-1:0] CMD_START = 2'd1;
	localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;
	localparam logic [CMD_W-1:0] CMD_FLUSH = 2'd3;

	// Operation classes; the spare code runs on the ALU pool
	localparam logic [CLS_W-1:0] CLS_ALU    = 2'd0;
	localparam logic [CLS_W-1:0] CLS_BRANCH = 2'd1;
	localparam logic [CLS_W-1:0] CLS_MEMORY = 2'd2;
	localparam logic [CLS_W-1:0] CLS_SPARE  = 2'd3;

	// Result kinds
	localparam logic [KIND_W-1:0] KIND_ANSWER  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DONE    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_NONE    = 2'd2;
	localparam logic [KIND_W-1:0] KIND_FLUSHED = 2'd3;

	// Register indexes
	localparam logic [REG_IDX_W-1:0] REG_ALU_POOL    = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_BRANCH_POOL = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_MEMORY_POOL = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_ALU_DELAY   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_BRANCH_DELAY = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_MEMORY_DELAY = 3'd5;

	// Register reset values
	localparam logic [POOL_W-1:0]  POOL_RESET  = 3'd4;
	localparam logic [DELAY_W-1:0] DELAY_RESET = 8'd1;

	typedef struct packed {
		logic [CMD_W-1:0] command;
		logic [CLS_W-1:0] cls;
		logic [TAG_W-1:0] seq_tag;
		logic [XD_W-1:0]  extra_delay;
	} op_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [TAG_W-1:0]  done_tag;
		logic              can_accept;
		logic              rejected;
		logic              last;
	} res_t;

	typedef struct packed {
		logic [NUM_CLASSES-1:0][POOL_W-1:0]  pool_size;
		logic [NUM_CLASSES-1:0][DELAY_W-1:0] delay;
	} cfg_regs_t;

endpackage

`default_nettype wire

// ----- hw/rtl/eot_ifs.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Operation word channel
interface eot_op_if import eot_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CMD_W-1:0] command;
	logic [CLS_W-1:0] op_class;
	logic [TAG_W-1:0] seq_tag;
	logic [XD_W-1:0]  extra_delay;

	modport source (output valid, command, op_class, seq_tag, extra_delay, input ready);
	modport sink (input valid, command, op_class, seq_tag, extra_delay, output ready);
endinterface

// Result word channel
interface eot_res_if import eot_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [TAG_W-1:0]  done_tag;
	logic              can_accept;
	logic              rejected;
	logic              last;

	modport source (output valid, kind, done_tag, can_accept, rejected, last, input ready);
	modport sink (input valid, kind, done_tag, can_accept, rejected, last, output ready);
endinterface

// Register write channel
interface eot_cfg_if import eot_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [REG_IDX_W-1:0]  index;
	logic [REG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/eot_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module eot_front import eot_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	eot_op_if.sink ops,
	output logic push_valid,
	output op_t  push_item,
	input  logic push_ready
);

	logic valid_s1;
	op_t  item_s1;
	op_t  item_d;
	logic take;

	// Fold the spare class code onto the ALU pool
	always_comb begin
		item_d.command     = ops.command;
		item_d.cls         = (ops.op_class == CLS_SPARE) ? CLS_ALU : ops.op_class;
		item_d.seq_tag     = ops.seq_tag;
		item_d.extra_delay = ops.extra_delay;
	end

	assign ops.ready  = !valid_s1 || push_ready;
	assign take       = ops.valid && ops.ready;
	assign push_valid = valid_s1;
	assign push_item  = item_s1;

	// Hold the classified word until the queue takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item_d;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/eot_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module eot_queue import eot_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  op_t  in_item,
	output logic in_ready,
	output logic out_valid,
	output op_t  out_item,
	input  logic out_pop
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	op_t              mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign in_ready  = (count_q != CNT_W'(QUEUE_DEPTH));
	assign out_valid = (count_q != '0);
	assign out_item  = mem_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_pop && out_valid;

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_item;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/eot_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module eot_back import eot_pkg::*; #(
	parameter int SLOTS_PER_CLASS = SLOTS_PER_CLASS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_regs_t cfg,
	input  logic      q_valid,
	input  op_t       q_item,
	output logic      q_pop,
	output logic      res_valid,
	output res_t      res,
	input  logic      res_ready
);

	localparam int TOTAL  = NUM_CLASSES * SLOTS_PER_CLASS;
	localparam int IDX_W  = $clog2(TOTAL);
	localparam int SCNT_W = $clog2(TOTAL + 1);
	localparam int ACT_W  = $clog2(SLOTS_PER_CLASS + 1);
	localparam int CMP_W  = (ACT_W > POOL_W) ? ACT_W : POOL_W;
	localparam int SUB_W  = (SLOTS_PER_CLASS > 1) ? $clog2(SLOTS_PER_CLASS) : 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	localparam logic MODE_TICK  = 1'b0;
	localparam logic MODE_FLUSH = 1'b1;

	logic [1:0]        state_q;
	logic              mode_q;
	logic [SCNT_W-1:0] scan_q;
	logic              rd_v_s1;
	logic [IDX_W-1:0]  rd_idx_s1;
	logic [TAG_W-1:0]  rd_tag_s1;
	logic [TOTAL-1:0]  busy_q;
	logic [TOTAL-1:0]  done_q;
	logic [TAG_W-1:0]  bound_q;
	logic [TAG_W-1:0]  tag_mem [TOTAL];
	logic [CD_W-1:0]   cd_q [TOTAL];
	logic [TAG_W-1:0]  sort_q [TOTAL];
	logic [TAG_W-1:0]  sort_d [TOTAL];
	logic [SCNT_W-1:0] n_q;
	logic              res_valid_q;
	res_t              res_q;
	res_t              res_d;
	logic              load_res;

	logic                       out_free;
	logic                       dispatch;
	logic [SLOTS_PER_CLASS-1:0] cls_busy;
	logic [ACT_W-1:0]           active;
	logic [SUB_W-1:0]           free_sub;
	logic                       room;
	logic [IDX_W-1:0]           start_addr;
	logic [CD_W-1:0]            lat_sum;
	logic [CD_W-1:0]            lat;
	logic [TOTAL-1:0]           tick_done;
	logic                       issue;
	logic                       insert_en;
	logic                       flush_clr;
	logic                       do_start;
	logic                       do_tick;
	logic [TOTAL-1:0]           gt;

	assign out_free  = !res_valid_q || res_ready;
	assign dispatch  = (state_q == ST_IDLE) && q_valid && out_free;
	assign q_pop     = dispatch;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// Occupancy of the addressed pool and its lowest free slot
	always_comb begin
		cls_busy = busy_q[int'(q_item.cls) * SLOTS_PER_CLASS +: SLOTS_PER_CLASS];
		active   = '0;
		free_sub = '0;
		for (int s = SLOTS_PER_CLASS - 1; s >= 0; s--) begin
			active = active + ACT_W'(cls_busy[s]);
			if (!cls_busy[s]) begin
				free_sub = SUB_W'(s);
			end
		end
		room       = !(&cls_busy) && (CMP_W'(active) < CMP_W'(cfg.pool_size[q_item.cls]));
		start_addr = IDX_W'(int'(q_item.cls) * SLOTS_PER_CLASS + int'(free_sub));
		lat_sum    = {1'b0, cfg.delay[q_item.cls]} + {1'b0, q_item.extra_delay};
		lat        = (lat_sum == '0) ? CD_W'(1) : lat_sum;
	end

	// Slots that finish on this tick
	always_comb begin
		for (int s = 0; s < TOTAL; s++) begin
			tick_done[s] = busy_q[s] && (cd_q[s] <= CD_W'(1));
		end
	end

	assign do_start  = dispatch && (q_item.command == CMD_START) && room;
	assign do_tick   = dispatch && (q_item.command == CMD_TICK);
	assign issue     = (state_q == ST_SCAN) && (scan_q != SCNT_W'(TOTAL));
	assign insert_en = rd_v_s1 && (mode_q == MODE_TICK) && done_q[rd_idx_s1];
	assign flush_clr = rd_v_s1 && (mode_q == MODE_FLUSH) && busy_q[rd_idx_s1]
		&& (rd_tag_s1 > bound_q);

	// Insert the scanned tag behind all entries not above it
	always_comb begin
		for (int i = 0; i < TOTAL; i++) begin
			gt[i] = (SCNT_W'(i) < n_q) && (sort_q[i] > rd_tag_s1);
		end
		for (int i = 0; i < TOTAL; i++) begin
			sort_d[i] = sort_q[i];
			if ((SCNT_W'(i) < n_q) && !gt[i]) begin
				sort_d[i] = sort_q[i];
			end else if ((SCNT_W'(i) <= n_q) && (i == 0 || !gt[(i > 0) ? i - 1 : 0])) begin
				sort_d[i] = rd_tag_s1;
			end else if ((SCNT_W'(i) <= n_q) && (i > 0)) begin
				sort_d[i] = sort_q[(i > 0) ? i - 1 : 0];
			end
		end
	end

	// Build the next result word
	always_comb begin
		load_res = 1'b0;
		res_d    = '0;
		res_d.last = 1'b1;
		if (dispatch) begin
			case (q_item.command)
				CMD_QUERY: begin
					load_res         = 1'b1;
					res_d.kind       = KIND_ANSWER;
					res_d.can_accept = room;
				end
				CMD_START: begin
					load_res         = 1'b1;
					res_d.kind       = KIND_ANSWER;
					res_d.can_accept = room;
					res_d.rejected   = !room;
				end
				CMD_TICK: begin
					load_res   = (tick_done == '0);
					res_d.kind = KIND_NONE;
				end
				default: begin
					load_res = 1'b0;
				end
			endcase
		end else if ((state_q == ST_EMIT) && out_free) begin
			load_res = 1'b1;
			if (mode_q == MODE_TICK) begin
				res_d.kind     = KIND_DONE;
				res_d.done_tag = sort_q[0];
				res_d.last     = (n_q == SCNT_W'(1));
			end else begin
				res_d.kind = KIND_FLUSHED;
			end
		end
	end

	// Sequencer, slot occupancy and result handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= MODE_TICK;
			scan_q      <= '0;
			rd_v_s1     <= 1'b0;
			busy_q      <= '0;
			done_q      <= '0;
			n_q         <= '0;
			res_valid_q <= 1'b0;
		end else begin
			rd_v_s1 <= issue;
			if (load_res) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			if (do_start) begin
				busy_q[start_addr] <= 1'b1;
			end
			if (do_tick) begin
				busy_q <= busy_q & ~tick_done;
				done_q <= tick_done;
			end
			if (flush_clr) begin
				busy_q[rd_idx_s1] <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (dispatch) begin
						scan_q <= '0;
						n_q    <= '0;
						if (do_tick && (tick_done != '0)) begin
							mode_q  <= MODE_TICK;
							state_q <= ST_SCAN;
						end else if (q_item.command == CMD_FLUSH) begin
							mode_q  <= MODE_FLUSH;
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (issue) begin
						scan_q <= scan_q + 1'b1;
					end else if (!rd_v_s1) begin
						state_q <= ST_EMIT;
					end
					if (insert_en) begin
						n_q <= n_q + 1'b1;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						if (mode_q == MODE_FLUSH || n_q == SCNT_W'(1)) begin
							state_q <= ST_IDLE;
						end
						if (mode_q == MODE_TICK) begin
							n_q <= n_q - 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Tag store: written by a start, read by the scan
	always_ff @(posedge clk) begin
		if (do_start) begin
			tag_mem[start_addr] <= q_item.seq_tag;
		end
		if (issue) begin
			rd_tag_s1 <= tag_mem[scan_q[IDX_W-1:0]];
			rd_idx_s1 <= scan_q[IDX_W-1:0];
		end
	end

	// Countdowns, flush boundary, sorted completions and result word
	always_ff @(posedge clk) begin
		if (do_start) begin
			cd_q[start_addr] <= lat;
		end
		if (do_tick) begin
			for (int s = 0; s < TOTAL; s++) begin
				if (busy_q[s] && !tick_done[s]) begin
					cd_q[s] <= cd_q[s] - 1'b1;
				end
			end
		end
		if (dispatch) begin
			bound_q <= q_item.seq_tag;
		end
		if (insert_en) begin
			sort_q <= sort_d;
		end else if ((state_q == ST_EMIT) && out_free && (mode_q == MODE_TICK)) begin
			for (int i = 0; i < TOTAL - 1; i++) begin
				sort_q[i] <= sort_q[i + 1];
			end
		end
		if (load_res) begin
			res_q <= res_d;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/execution_unit_occupancy_tracker.sv -----
// Query, start and a tick with no completion: result word registered behind the
// front stage and the queue, one word a cycle when such words come back to back and
// the receiver takes them. Tick with completions and flush: after dispatch a scan of
// the tag store, one slot a cycle, then the completion words (one word for a flush);
// the front stage and a two-entry queue keep accepting meanwhile.
// Reset clears the busy flags and loads the register reset values.
`timescale 1ns / 1ps
`default_nettype none

module execution_unit_occupancy_tracker import eot_pkg::*; #(
	parameter int SLOTS_PER_CLASS = SLOTS_PER_CLASS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	eot_op_if.sink    ops,
	eot_res_if.source results,
	eot_cfg_if.sink   cfg
);

	cfg_regs_t cfg_q;
	logic      f_valid;
	op_t       f_item;
	logic      f_ready;
	logic      q_valid;
	op_t       q_item;
	logic      q_pop;
	logic      r_valid;
	res_t      r_word;

	// Register writes are always taken
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pool_size <= {NUM_CLASSES{POOL_RESET}};
			cfg_q.delay     <= {NUM_CLASSES{DELAY_RESET}};
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_ALU_POOL:     cfg_q.pool_size[CLS_ALU]    <= cfg.data[POOL_W-1:0];
				REG_BRANCH_POOL:  cfg_q.pool_size[CLS_BRANCH] <= cfg.data[POOL_W-1:0];
				REG_MEMORY_POOL:  cfg_q.pool_size[CLS_MEMORY] <= cfg.data[POOL_W-1:0];
				REG_ALU_DELAY:    cfg_q.delay[CLS_ALU]        <= cfg.data;
				REG_BRANCH_DELAY: cfg_q.delay[CLS_BRANCH]     <= cfg.data;
				REG_MEMORY_DELAY: cfg_q.delay[CLS_MEMORY]     <= cfg.data;
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	eot_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.ops        (ops),
		.push_valid (f_valid),
		.push_item  (f_item),
		.push_ready (f_ready)
	);

	eot_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_item   (f_item),
		.in_ready  (f_ready),
		.out_valid (q_valid),
		.out_item  (q_item),
		.out_pop   (q_pop)
	);

	eot_back #(
		.SLOTS_PER_CLASS (SLOTS_PER_CLASS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.res_valid (r_valid),
		.res       (r_word),
		.res_ready (results.ready)
	);

	assign results.valid      = r_valid;
	assign results.kind       = r_word.kind;
	assign results.done_tag   = r_word.done_tag;
	assign results.can_accept = r_word.can_accept;
	assign results.rejected   = r_word.rejected;
	assign results.last       = r_word.last;

endmodule

`default_nettype wire

// ----- tb/execution_unit_occupancy_tracker_tb.sv -----
`timescale 1ns / 1ps

module execution_unit_occupancy_tracker_tb;
	import eot_pkg::*;

	localparam int POOL_SLOTS  = SLOTS_PER_CLASS_DEF;
	localparam int ALL_SLOTS   = NUM_CLASSES * POOL_SLOTS;
	localparam int CYCLE_LIMIT = 300000;
	localparam int HOLD_CYCLES = 400;
	localparam int SEG_ITEMS   = 33;

	typedef struct {
		op_t  op;
		bit   typed;
		res_t want;
	} stim_row_t;

	logic clk;
	logic arst_n;

	eot_op_if  op_ch();
	eot_res_if res_ch();
	eot_cfg_if cfg_ch();

	execution_unit_occupancy_tracker i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.ops     (op_ch),
		.results (res_ch),
		.cfg     (cfg_ch)
	);

	// Shadow copy of the tracker state and registers
	logic [POOL_W-1:0]  pool_limit [NUM_CLASSES];
	logic [DELAY_W-1:0] base_lat   [NUM_CLASSES];
	bit                 slot_live  [ALL_SLOTS];
	logic [TAG_W-1:0]   slot_seq   [ALL_SLOTS];
	logic [CD_W-1:0]    slot_left  [ALL_SLOTS];

	res_t        step_words[$];
	res_t        expected_words[$];
	stim_row_t   stim_rows[$];
	res_t        seen_word;
	res_t        oldest_word;
	logic [TAG_W-1:0] tag_base;

	int src_idle;
	int dst_idle;
	int error_count;
	int cycle_count;
	bit hold_go;
	bit hold_res;

	// Clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Work out the result words of one operation word and advance the shadow state
	function automatic void occupancy_step(input op_t op);
		int unsigned c;
		int unsigned cap;
		int unsigned active;
		int unsigned lat;
		int unsigned n;
		int unsigned j;
		int unsigned i;
		logic [TAG_W-1:0] done [ALL_SLOTS];
		res_t w;
		step_words.delete();
		c = (op.cls == CLS_SPARE) ? 0 : op.cls;
		cap = (pool_limit[c] > POOL_SLOTS) ? POOL_SLOTS : pool_limit[c];
		active = 0;
		for (int s = 0; s < POOL_SLOTS; s++)
			if (slot_live[c * POOL_SLOTS + s])
				active++;
		w = '0;
		w.last = 1'b1;
		case (op.command)
			CMD_QUERY: begin
				w.kind = KIND_ANSWER;
				w.can_accept = (active < cap);
				step_words.insert(step_words.size(), w);
			end
			CMD_START: begin
				w.kind = KIND_ANSWER;
				if (active >= cap) begin
					w.rejected = 1'b1;
				end else begin
					w.can_accept = 1'b1;
					// Take the lowest free slot of the pool
					for (int s = 0; s < POOL_SLOTS; s++) begin
						i = c * POOL_SLOTS + s;
						if (!slot_live[i]) begin
							lat = base_lat[c] + op.extra_delay;
							slot_live[i] = 1'b1;
							slot_seq[i] = op.seq_tag;
							slot_left[i] = CD_W'((lat < 1) ? 1 : lat);
							break;
						end
					end
				end
				step_words.insert(step_words.size(), w);
			end
			CMD_TICK: begin
				n = 0;
				// Count down, free expired slots and keep their tags sorted
				for (int s = 0; s < ALL_SLOTS; s++) begin
					if (slot_live[s]) begin
						if (slot_left[s] <= 1) begin
							slot_left[s] = '0;
							slot_live[s] = 1'b0;
							j = n;
							while (j > 0 && done[j-1] > slot_seq[s]) begin
								done[j] = done[j-1];
								j--;
							end
							done[j] = slot_seq[s];
							n++;
						end else begin
							slot_left[s] = slot_left[s] - 1'b1;
						end
					end
				end
				if (n == 0) begin
					w.kind = KIND_NONE;
					step_words.insert(step_words.size(), w);
				end else begin
					for (int k = 0; k < n; k++) begin
						w.kind = KIND_DONE;
						w.done_tag = done[k];
						w.last = (k == n - 1);
						step_words.insert(step_words.size(), w);
					end
				end
			end
			default: begin
				// Drop every slot younger than the boundary
				for (int s = 0; s < ALL_SLOTS; s++)
					if (slot_live[s] && slot_seq[s] > op.seq_tag)
						slot_live[s] = 1'b0;
				w.kind = KIND_FLUSHED;
				step_words.insert(step_words.size(), w);
			end
		endcase
	endfunction

	function automatic void add_row(input logic [CMD_W-1:0] cmd, input logic [CLS_W-1:0] cls,
			input logic [TAG_W-1:0] tag, input logic [XD_W-1:0] xd, input bit typed,
			input logic [KIND_W-1:0] kind, input bit acc, input bit rej);
		stim_row_t r;
		r.op.command = cmd;
		r.op.cls = cls;
		r.op.seq_tag = tag;
		r.op.extra_delay = xd;
		r.typed = typed;
		r.want = '0;
		r.want.kind = kind;
		r.want.can_accept = acc;
		r.want.rejected = rej;
		r.want.last = 1'b1;
		stim_rows.insert(stim_rows.size(), r);
	endfunction

	// Mostly rising tags so that flushes cut into live work
	function automatic op_t random_op();
		op_t op;
		int unsigned r;
		r = $urandom_range(99);
		if (r < 15)
			op.command = CMD_QUERY;
		else if (r < 50)
			op.command = CMD_START;
		else if (r < 85)
			op.command = CMD_TICK;
		else
			op.command = CMD_FLUSH;
		op.cls = ($urandom_range(9) == 0) ? CLS_SPARE : CLS_W'($urandom_range(2));
		r = $urandom_range(99);
		if (r < 70)
			op.extra_delay = XD_W'($urandom_range(4));
		else if (r < 85)
			op.extra_delay = XD_W'($urandom_range(255));
		else if (r < 93)
			op.extra_delay = 8'hFF;
		else
			op.extra_delay = 8'h00;
		if (op.command == CMD_FLUSH) begin
			if ($urandom_range(9) == 0)
				op.seq_tag = $urandom;
			else
				op.seq_tag = tag_base - $urandom_range(6);
		end else if ($urandom_range(19) == 0) begin
			op.seq_tag = $urandom;
		end else begin
			tag_base = tag_base + $urandom_range(1, 3);
			op.seq_tag = tag_base;
		end
		return op;
	endfunction

	task automatic note_error(input string msg);
		error_count++;
		if (error_count <= 10)
			$display("mismatch: %s", msg);
	endtask

	// Offer one operation word, hold it until taken, then queue its result words
	task automatic send_op(input op_t op, input bit typed, input res_t want);
		bit taken;
		@(negedge clk);
		while ($urandom_range(99) < src_idle) begin
			op_ch.valid <= 1'b0;
			@(negedge clk);
		end
		op_ch.valid       <= 1'b1;
		op_ch.command     <= op.command;
		op_ch.op_class    <= op.cls;
		op_ch.seq_tag     <= op.seq_tag;
		op_ch.extra_delay <= op.extra_delay;
		taken = 1'b0;
		while (!taken) begin
			@(posedge clk);
			taken = op_ch.ready;
		end
		occupancy_step(op);
		if (typed)
			expected_words.insert(expected_words.size(), want);
		else
			foreach (step_words[k])
				expected_words.insert(expected_words.size(), step_words[k]);
	endtask

	// Write one register and mirror it in the shadow copy
	task automatic cfg_write(input logic [REG_IDX_W-1:0] idx, input logic [REG_DATA_W-1:0] data);
		bit taken;
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		taken = 1'b0;
		while (!taken) begin
			@(posedge clk);
			taken = cfg_ch.ready;
		end
		case (idx)
			REG_ALU_POOL:     pool_limit[0] = data[POOL_W-1:0];
			REG_BRANCH_POOL:  pool_limit[1] = data[POOL_W-1:0];
			REG_MEMORY_POOL:  pool_limit[2] = data[POOL_W-1:0];
			REG_ALU_DELAY:    base_lat[0] = data;
			REG_BRANCH_DELAY: base_lat[1] = data;
			REG_MEMORY_DELAY: base_lat[2] = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic apply_setting(input int p0, input int p1, input int p2,
			input int d0, input int d1, input int d2);
		cfg_write(REG_ALU_POOL, REG_DATA_W'(p0));
		cfg_write(REG_BRANCH_POOL, REG_DATA_W'(p1));
		cfg_write(REG_MEMORY_POOL, REG_DATA_W'(p2));
		cfg_write(REG_ALU_DELAY, REG_DATA_W'(d0));
		cfg_write(REG_BRANCH_DELAY, REG_DATA_W'(d1));
		cfg_write(REG_MEMORY_DELAY, REG_DATA_W'(d2));
	endtask

	// Drop valid and wait for every outstanding result word
	task automatic wait_drained();
		@(negedge clk);
		op_ch.valid <= 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
	endtask

	// Receiver: random stalls, plus one long hold-off
	always @(negedge clk)
		res_ch.ready <= !hold_res && ($urandom_range(99) >= dst_idle);

	initial begin
		hold_res = 1'b0;
		wait (hold_go);
		@(posedge clk);
		hold_res = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_res = 1'b0;
	end

	// Compare each result word with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready) begin
			seen_word.kind       = res_ch.kind;
			seen_word.done_tag   = res_ch.done_tag;
			seen_word.can_accept = res_ch.can_accept;
			seen_word.rejected   = res_ch.rejected;
			seen_word.last       = res_ch.last;
			if (expected_words.size() == 0) begin
				note_error($sformatf("unexpected word kind=%0d tag=%h acc=%b rej=%b last=%b",
					seen_word.kind, seen_word.done_tag, seen_word.can_accept,
					seen_word.rejected, seen_word.last));
			end else begin
				oldest_word = expected_words.pop_front();
				if (seen_word !== oldest_word)
					note_error($sformatf({"expected kind=%0d tag=%h acc=%b rej=%b last=%b, ",
						"got kind=%0d tag=%h acc=%b rej=%b last=%b"},
						oldest_word.kind, oldest_word.done_tag, oldest_word.can_accept,
						oldest_word.rejected, oldest_word.last,
						seen_word.kind, seen_word.done_tag, seen_word.can_accept,
						seen_word.rejected, seen_word.last));
			end
		end
	end

	// Watchdog
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		op_ch.valid = 1'b0;
		op_ch.command = CMD_QUERY;
		op_ch.op_class = CLS_ALU;
		op_ch.seq_tag = '0;
		op_ch.extra_delay = '0;
		res_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_ALU_POOL;
		cfg_ch.data = '0;
		error_count = 0;
		hold_go = 1'b0;
		tag_base = 32'h100;
		src_idle = 13;
		dst_idle = 71;
		for (int c = 0; c < NUM_CLASSES; c++) begin
			pool_limit[c] = POOL_RESET;
			base_lat[c] = DELAY_RESET;
		end
		for (int s = 0; s < ALL_SLOTS; s++) begin
			slot_live[s] = 1'b0;
			slot_seq[s] = '0;
			slot_left[s] = '0;
		end

		// Directed rows on reset settings
		add_row(CMD_QUERY, CLS_ALU,    32'h0,        8'h00, 1, KIND_ANSWER,  1, 0);
		add_row(CMD_QUERY, CLS_SPARE,  32'h0,        8'h00, 1, KIND_ANSWER,  1, 0);
		add_row(CMD_TICK,  CLS_ALU,    32'h0,        8'h00, 1, KIND_NONE,    0, 0);
		add_row(CMD_FLUSH, CLS_ALU,    32'h0,        8'h00, 1, KIND_FLUSHED, 0, 0);
		// Fill every pool, the spare class landing in the ALU pool
		add_row(CMD_START, CLS_ALU,    32'hFFFFFFFF, 8'h00, 1, KIND_ANSWER,  1, 0);
		add_row(CMD_START, CLS_SPARE,  32'h7,        8'h00, 1, KIND_ANSWER,  1, 0);
		add_row(CMD_START, CLS_ALU,    32'h7,        8'h00, 1, KIND_ANSWER,  1, 0);
		add_row(CMD_START, CLS_ALU,    32'h3,        8'h00, 1, KIND_ANSWER,  1, 0);
		add_row(CMD_START, CLS_ALU,    32'h4,        8'h00, 1, KIND_ANSWER,  0, 1);
		add_row(CMD_QUERY, CLS_ALU,    32'h0,        8'h00, 1, KIND_ANSWER,  0, 0);
		add_row(CMD_START, CLS_BRANCH, 32'h0,        8'h00, 1, KIND_ANSWER,  1, 0);
		add_row(CMD_START, CLS_BRANCH, 32'h9,        8'h00, 1, KIND_ANSWER,  1, 0);
		add_row(CMD_START, CLS_BRANCH, 32'h2,        8'h00, 1, KIND_ANSWER,  1, 0);
		add_row(CMD_START, CLS_BRANCH, 32'h9,        8'h00, 1, KIND_ANSWER,  1, 0);
		add_row(CMD_START, CLS_MEMORY, 32'h1,        8'h00, 1, KIND_ANSWER,  1, 0);
		add_row(CMD_START, CLS_MEMORY, 32'h64,       8'h00, 1, KIND_ANSWER,  1, 0);
		add_row(CMD_START, CLS_MEMORY, 32'h32,       8'h00, 1, KIND_ANSWER,  1, 0);
		add_row(CMD_START, CLS_MEMORY, 32'h8,        8'h00, 1, KIND_ANSWER,  1, 0);
		// All twelve complete together, equal tags among them
		add_row(CMD_TICK,  CLS_ALU,    32'h0,        8'h00, 0, KIND_DONE,    0, 0);
		add_row(CMD_START, CLS_BRANCH, 32'h0,        8'hFF, 1, KIND_ANSWER,  1, 0);
		add_row(CMD_START, CLS_ALU,    32'h80000000, 8'hFF, 1, KIND_ANSWER,  1, 0);
		add_row(CMD_FLUSH, CLS_MEMORY, 32'h7FFFFFFF, 8'hFF, 1, KIND_FLUSHED, 0, 0);
		add_row(CMD_QUERY, CLS_ALU,    32'h0,        8'h00, 1, KIND_ANSWER,  1, 0);
		add_row(CMD_TICK,  CLS_SPARE,  32'hFFFFFFFF, 8'hFF, 1, KIND_NONE,    0, 0);
		add_row(CMD_FLUSH, CLS_BRANCH, 32'hFFFFFFFF, 8'h00, 1, KIND_FLUSHED, 0, 0);

		// Reset
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (stim_rows[r])
			send_op(stim_rows[r].op, stim_rows[r].typed, stim_rows[r].want);
		wait_drained();

		// Random segments, each on its own register setting
		for (int seg = 0; seg < 6; seg++) begin
			case (seg / 2)
				0: begin src_idle = 13; dst_idle = 71; end
				1: begin src_idle = 71; dst_idle = 13; end
				default: begin src_idle = 0; dst_idle = 0; end
			endcase
			case (seg)
				0: apply_setting(4, 4, 4, 0, 0, 0);
				1: apply_setting(0, 7, 5, 2, 255, 1);
				2: apply_setting(1, 2, 3, 3, 0, 255);
				3: apply_setting(6, 0, 4, 1, 2, 0);
				4: apply_setting(4, 4, 4, 1, 1, 1);
				default: apply_setting(7, 3, 2, 255, 255, 255);
			endcase
			// Hold the receiver off while words keep coming
			if (seg == 4)
				hold_go = 1'b1;
			repeat (SEG_ITEMS) send_op(random_op(), 1'b0, '0);
			wait_drained();
		end

		repeat (30) @(posedge clk);
		if (error_count == 0 && expected_words.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ----- files.f -----
hw/rtl/eot_pkg.sv
hw/rtl/eot_ifs.sv
hw/rtl/eot_front.sv
hw/rtl/eot_queue.sv
hw/rtl/eot_back.sv
hw/rtl/execution_unit_occupancy_tracker.sv
tb/execution_unit_occupancy_tracker_tb.sv
